// ----- design/sfc_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfc_pkg: shared types and helpers for the SPI frame checker
// Request and result layouts, register indexes, status codes and the
// frame builder with odd parity in bit 0.
// -----------------------------------------------------------------------------
package sfc_pkg;

    localparam int unsigned FRAME_W  = 16;
    localparam int unsigned BUDGET_W = 8;

    localparam logic [FRAME_W-1:0]  NIBBLE_MASK  = 16'hF000;
    localparam logic [FRAME_W-1:0]  PARITY_CLEAR = 16'hFFFE;
    localparam logic [FRAME_W-1:0]  PARITY_BIT   = 16'h0001;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 8'd3;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_REPLY  = 2'd1,
        KIND_RELOAD = 2'd2
    } t_kind;

    // Notification status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_WRONG = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic {
        REG_DUMMY_COMMAND = 1'b0,
        REG_RETRY_BUDGET  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FRAME_W-1:0] default_word;
        logic [FRAME_W-1:0] field_mask;
        logic [FRAME_W-1:0] field_data;
        logic [FRAME_W-1:0] reply_word;
    } t_item;

    typedef struct packed {
        logic               tx_valid;
        logic [FRAME_W-1:0] tx_frame;
        logic               notify_valid;
        logic [1:0]         notify_status;
        logic [FRAME_W-1:0] notify_word;
    } t_result;

    typedef struct packed {
        logic [FRAME_W-1:0]  dummy_command;
        logic [BUDGET_W-1:0] retry_budget;
    } t_cfg;

    // Merge data under mask, then force odd parity through bit 0
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [FRAME_W-1:0] dflt,
        input logic [FRAME_W-1:0] mask,
        input logic [FRAME_W-1:0] data
    );
        logic [FRAME_W-1:0] f;
        f = ((dflt & ~mask) | (data & mask)) & PARITY_CLEAR;
        if (!(^f)) begin
            f = f | PARITY_BIT;
        end
        return f;
    endfunction

endpackage

// ----- design/sfc_in_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfc_in_if: request channel
// Valid/ready channel carrying one send, reply or reload request.
// -----------------------------------------------------------------------------
interface sfc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] default_word;
    logic [15:0] field_mask;
    logic [15:0] field_data;
    logic [15:0] reply_word;

    modport source (
        output valid, kind, default_word, field_mask, field_data, reply_word,
        input  ready
    );
    modport sink (
        input  valid, kind, default_word, field_mask, field_data, reply_word,
        output ready
    );
endinterface

// ----- design/sfc_out_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfc_out_if: result channel
// Valid/ready channel carrying the transmit frame and the notification.
// -----------------------------------------------------------------------------
interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [15:0] tx_frame;
    logic        notify_valid;
    logic [1:0]  notify_status;
    logic [15:0] notify_word;

    modport source (
        output valid, tx_valid, tx_frame, notify_valid, notify_status, notify_word,
        input  ready
    );
    modport sink (
        input  valid, tx_valid, tx_frame, notify_valid, notify_status, notify_word,
        output ready
    );
endinterface

// ----- design/sfc_cfg_regs.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfc_cfg_regs: configuration registers
// Dummy command frame and retry budget, written through a plain write port.
// -----------------------------------------------------------------------------
module sfc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    output sfc_pkg::t_cfg o_cfg
);
    import sfc_pkg::*;

    logic [FRAME_W-1:0]  r_dummy_command;
    logic [BUDGET_W-1:0] r_retry_budget;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dummy_command <= '0;
            r_retry_budget  <= BUDGET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DUMMY_COMMAND: r_dummy_command <= i_cfg_data;
                REG_RETRY_BUDGET:  r_retry_budget  <= i_cfg_data[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.dummy_command = r_dummy_command;
    assign o_cfg.retry_budget  = r_retry_budget;

endmodule

// ----- design/sfc_engine.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfc_engine: exchange state and decision logic
// Holds the stored command, dummy-pending flag and retry counter, and forms
// the result for the request in the input register in one pass.
// -----------------------------------------------------------------------------
module sfc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  sfc_pkg::t_item   i_item,
    input  sfc_pkg::t_cfg    i_cfg,
    output sfc_pkg::t_result o_res
);
    import sfc_pkg::*;

    logic [FRAME_W-1:0]  r_stored_command, n_stored_command;
    logic                r_dummy_pending,  n_dummy_pending;
    logic [BUDGET_W-1:0] r_retries_left,   n_retries_left;

    logic [FRAME_W-1:0] built;
    logic               reply_zero;
    logic               dummy_miss;
    logic               stored_miss;

    assign built       = build_frame(i_item.default_word, i_item.field_mask,
                                     i_item.field_data);
    assign reply_zero  = (i_item.reply_word == '0);
    assign dummy_miss  = ((i_cfg.dummy_command & NIBBLE_MASK)
                          != (i_item.reply_word & NIBBLE_MASK));
    assign stored_miss = ((r_stored_command & NIBBLE_MASK)
                          != (i_item.reply_word & NIBBLE_MASK));

    // Decision per request kind
    always_comb begin
        n_stored_command = r_stored_command;
        n_dummy_pending  = r_dummy_pending;
        n_retries_left   = r_retries_left;
        o_res            = '0;
        case (i_item.kind)
            KIND_SEND: begin
                n_stored_command = built;
                n_dummy_pending  = 1'b0;
                o_res.tx_valid   = 1'b1;
                o_res.tx_frame   = built;
            end
            KIND_REPLY: begin
                if (!r_dummy_pending) begin
                    // reply to an earlier frame: zero is accepted too
                    if (dummy_miss && !reply_zero) begin
                        o_res.notify_valid  = 1'b1;
                        o_res.notify_status = ST_WRONG;
                        o_res.notify_word   = i_item.reply_word;
                    end else begin
                        n_dummy_pending = 1'b1;
                        o_res.tx_valid  = 1'b1;
                        o_res.tx_frame  = i_cfg.dummy_command;
                    end
                end else if (reply_zero) begin
                    // device lost the command: resend or give up
                    if (r_retries_left != '0) begin
                        n_retries_left  = r_retries_left - 1'b1;
                        n_dummy_pending = 1'b0;
                        o_res.tx_valid  = 1'b1;
                        o_res.tx_frame  = r_stored_command;
                    end else begin
                        o_res.notify_valid  = 1'b1;
                        o_res.notify_status = ST_FAIL;
                        o_res.notify_word   = i_item.reply_word;
                    end
                end else begin
                    o_res.notify_valid  = 1'b1;
                    o_res.notify_status = stored_miss ? ST_WRONG : ST_OK;
                    o_res.notify_word   = i_item.reply_word;
                end
            end
            KIND_RELOAD: begin
                n_retries_left = i_cfg.retry_budget;
            end
            default: ;
        endcase
    end

    // State update when the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_command <= '0;
            r_dummy_pending  <= 1'b0;
            r_retries_left   <= '0;
        end else if (i_fire) begin
            r_stored_command <= n_stored_command;
            r_dummy_pending  <= n_dummy_pending;
            r_retries_left   <= n_retries_left;
        end
    end

endmodule

// ----- design/spi_frame_check_with_retry.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// spi_frame_check_with_retry: SPI master exchange checker with resend budget
// Builds command frames, fetches one-frame-late replies with a dummy frame,
// checks the echoed command nibble and resends on an empty reply.
// -----------------------------------------------------------------------------
// Usage:
//   i_in  : request channel (valid/ready). kind 0 sends a command built from
//           default_word/field_mask/field_data, kind 1 hands in a received
//           reply_word, kind 2 reloads the retry counter from retry_budget.
//   o_res : one result per request: a frame to transmit (tx_valid/tx_frame)
//           and/or a notification (notify_valid/status/word).
//   cfg   : i_cfg_we/i_cfg_idx/i_cfg_data; index 0 dummy command, 1 retry
//           budget. Write only while no request is in flight.
// Pipeline: two register stages (input and result register); a request is
//   decided as it moves from the input register into the result register.
// Throughput: one request per cycle unless the result stalls; the state
//   update is one pass of merge, parity and nibble compare between registers.
// Reset: synchronous, clears both stages, the stored command, the pending
//   flag and the retry counter; budget resets to 3, dummy command to 0.
// Stall: with o_res.ready low the result holds; one more request is still
//   taken into the input register, after which i_in.ready drops.
// -----------------------------------------------------------------------------
module spi_frame_check_with_retry (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfc_in_if.sink    i_in,
    sfc_out_if.source o_res,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import sfc_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    out_free;
    logic    fire;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;

    sfc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Pipeline flow control
    assign out_free   = !r_out_valid || o_res.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.kind         <= i_in.kind;
            r_item.default_word <= i_in.default_word;
            r_item.field_mask   <= i_in.field_mask;
            r_item.field_data   <= i_in.field_data;
            r_item.reply_word   <= i_in.reply_word;
        end
    end

    sfc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.tx_valid      = r_res.tx_valid;
    assign o_res.tx_frame      = r_res.tx_frame;
    assign o_res.notify_valid  = r_res.notify_valid;
    assign o_res.notify_status = r_res.notify_status;
    assign o_res.notify_word   = r_res.notify_word;

endmodule

// ----- design/sfc_check.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfc_check: port-level checks for the SPI frame checker
// Watches the result channel and reset behavior of the top level.
// -----------------------------------------------------------------------------
module sfc_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_tx_valid,
    input logic [15:0] i_tx_frame,
    input logic        i_notify_valid,
    input logic [1:0]  i_notify_status,
    input logic [15:0] i_notify_word
);
    import sfc_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_valid)
        && $stable(i_tx_frame) && $stable(i_notify_valid)
        && $stable(i_notify_status) && $stable(i_notify_word))
        else $error("result changed while stalled");

    // A result never both transmits and notifies
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_tx_valid && i_notify_valid))
        else $error("transmit and notify in one result");

    // Unused fields read as zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_tx_valid || i_tx_frame == '0)
        && (i_notify_valid || (i_notify_status == ST_OK && i_notify_word == '0)))
        else $error("inactive result field not zero");

    // Failure is only reported for an empty reply
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_notify_valid && i_notify_status == ST_FAIL
        |-> i_notify_word == '0)
        else $error("failure reported for non-empty reply");

    // Reset empties the result register
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind spi_frame_check_with_retry sfc_check u_sfc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_tx_valid      (o_res.tx_valid),
    .i_tx_frame      (o_res.tx_frame),
    .i_notify_valid  (o_res.notify_valid),
    .i_notify_status (o_res.notify_status),
    .i_notify_word   (o_res.notify_word)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top: self-checking bench for spi_frame_check_with_retry
// Drives send, reply, reload and unused-kind requests into the request channel
// under random bursts and result stalls. Every accepted request is run through
// a local model of the frame builder, dummy fetch and resend logic. Each
// accepted result is compared field by field against the oldest prediction.
// The run covers several dummy command and retry budget settings.
// -----------------------------------------------------------------------------
module tb_top;
    import sfc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int NUM_PHASES    = 5;

    // Tracks exchange state and queues the predicted result of each request
    class frame_scoreboard;
        logic [15:0] dummy_cmd;
        logic [7:0]  budget;
        logic [15:0] stored_cmd;
        bit          dummy_pending;
        logic [7:0]  retries_left;
        t_result     pending_results[$];
        int          mismatches;

        function new();
            dummy_cmd     = '0;
            budget        = BUDGET_RESET;
            stored_cmd    = '0;
            dummy_pending = 1'b0;
            retries_left  = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] data);
            if (idx == REG_DUMMY_COMMAND) begin
                dummy_cmd = data;
            end else begin
                budget = data[7:0];
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Merge under mask, bit 0 forced so the frame has an odd count of ones
        function logic [15:0] odd_parity_frame(logic [15:0] dflt, logic [15:0] mask,
                                               logic [15:0] data);
            logic [15:0] f;
            f = (dflt & ~mask) | (data & mask);
            f[0] = 1'b0;
            f[0] = ~^f;
            return f;
        endfunction

        function void note_request(t_item req);
            t_result r;
            r = '0;
            case (req.kind)
                KIND_SEND: begin
                    stored_cmd    = odd_parity_frame(req.default_word, req.field_mask,
                                                     req.field_data);
                    dummy_pending = 1'b0;
                    r.tx_valid    = 1'b1;
                    r.tx_frame    = stored_cmd;
                end
                KIND_REPLY: begin
                    if (!dummy_pending) begin
                        // Reply to an earlier frame: zero or dummy nibble fetches
                        if (req.reply_word != 16'h0000 &&
                            (req.reply_word & NIBBLE_MASK) != (dummy_cmd & NIBBLE_MASK)) begin
                            r.notify_valid  = 1'b1;
                            r.notify_status = ST_WRONG;
                            r.notify_word   = req.reply_word;
                        end else begin
                            dummy_pending = 1'b1;
                            r.tx_valid    = 1'b1;
                            r.tx_frame    = dummy_cmd;
                        end
                    end else if (req.reply_word == 16'h0000) begin
                        // Empty reply: resend while the budget lasts
                        if (retries_left != 8'd0) begin
                            retries_left  = retries_left - 8'd1;
                            dummy_pending = 1'b0;
                            r.tx_valid    = 1'b1;
                            r.tx_frame    = stored_cmd;
                        end else begin
                            r.notify_valid  = 1'b1;
                            r.notify_status = ST_FAIL;
                            r.notify_word   = req.reply_word;
                        end
                    end else begin
                        r.notify_valid  = 1'b1;
                        r.notify_status = ((req.reply_word & NIBBLE_MASK) ==
                                           (stored_cmd & NIBBLE_MASK)) ? ST_OK : ST_WRONG;
                        r.notify_word   = req.reply_word;
                    end
                end
                KIND_RELOAD: begin
                    retries_left = budget;
                end
                default: begin
                    // unused kind: no effect, all-zero result
                end
            endcase
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.tx_valid !== want.tx_valid)
                report_mismatch($sformatf("tx_valid got %b want %b",
                                          got.tx_valid, want.tx_valid));
            if (got.tx_frame !== want.tx_frame)
                report_mismatch($sformatf("tx_frame got %h want %h",
                                          got.tx_frame, want.tx_frame));
            if (got.notify_valid !== want.notify_valid)
                report_mismatch($sformatf("notify_valid got %b want %b",
                                          got.notify_valid, want.notify_valid));
            if (got.notify_status !== want.notify_status)
                report_mismatch($sformatf("notify_status got %0d want %0d",
                                          got.notify_status, want.notify_status));
            if (got.notify_word !== want.notify_word)
                report_mismatch($sformatf("notify_word got %h want %h",
                                          got.notify_word, want.notify_word));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    sfc_in_if  in_ch ();
    sfc_out_if res_ch ();

    frame_scoreboard sb;
    int burst_left;
    int quiet_cycles;

    spi_frame_check_with_retry u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Request with random filler in every field, kind set by caller
    function automatic t_item filler_item(logic [1:0] kind);
        t_item req;
        req.kind         = kind;
        req.default_word = 16'($urandom);
        req.field_mask   = 16'($urandom);
        req.field_data   = 16'($urandom);
        req.reply_word   = 16'($urandom);
        return req;
    endfunction

    function automatic t_item send_item(logic [15:0] dflt, logic [15:0] mask,
                                        logic [15:0] data);
        t_item req;
        req = filler_item(KIND_SEND);
        req.default_word = dflt;
        req.field_mask   = mask;
        req.field_data   = data;
        return req;
    endfunction

    function automatic t_item reply_item(logic [15:0] word);
        t_item req;
        req = filler_item(KIND_REPLY);
        req.reply_word = word;
        return req;
    endfunction

    // Offer one request, wait for acceptance, then maybe end the burst
    task automatic offer(t_item req);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= req.kind;
        in_ch.default_word <= req.default_word;
        in_ch.field_mask   <= req.field_mask;
        in_ch.field_data   <= req.field_data;
        in_ch.reply_word   <= req.reply_word;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(req);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and let every outstanding result drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write enable high; caller lowers it after the last write
    task automatic write_reg(t_reg_idx idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Mostly well-formed exchanges steered by the tracked state
    function automatic t_item random_item();
        int pick;
        int sub;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < 6)
            return filler_item(KIND_RELOAD);
        if (pick < 9)
            return filler_item(2'd3);
        if (pick < 35) begin
            if (sub < 10)
                return send_item(16'($urandom), 16'h0000, 16'($urandom));
            if (sub < 20)
                return send_item(16'($urandom), 16'hFFFF, 16'($urandom));
            return filler_item(KIND_SEND);
        end
        if (!sb.dummy_pending) begin
            if (sub < 60)
                return reply_item({sb.dummy_cmd[15:12], 12'($urandom)});
            if (sub < 80)
                return reply_item(16'h0000);
            return filler_item(KIND_REPLY);
        end
        if (sub < 30)
            return reply_item(16'h0000);
        if (sub < 70)
            return reply_item({sb.stored_cmd[15:12], 12'($urandom)});
        return filler_item(KIND_REPLY);
    endfunction

    // Result sink: ready pattern changes per segment, a forced long hold-off early
    initial begin : result_ready_gen
        int seg;
        int len;
        int mode;
        int pct;
        int on_len;
        int off_len;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        seg = 0;
        forever begin
            mode = (seg == 2) ? 3 : $urandom_range(0, 2);
            if (seg != 2 && $urandom_range(0, 39) == 0) mode = 3;
            case (mode)
                0: begin
                    len = $urandom_range(10, 60);
                    repeat (len) begin
                        @(posedge i_clk);
                        res_ch.ready <= 1'b1;
                    end
                end
                1: begin
                    len = $urandom_range(10, 60);
                    pct = $urandom_range(10, 90);
                    repeat (len) begin
                        @(posedge i_clk);
                        res_ch.ready <= ($urandom_range(0, 99) < pct);
                    end
                end
                2: begin
                    on_len  = $urandom_range(1, 4);
                    off_len = $urandom_range(1, 4);
                    repeat ($urandom_range(3, 10)) begin
                        repeat (on_len) begin
                            @(posedge i_clk);
                            res_ch.ready <= 1'b1;
                        end
                        repeat (off_len) begin
                            @(posedge i_clk);
                            res_ch.ready <= 1'b0;
                        end
                    end
                end
                default: begin
                    // long hold-off so the block backs up into the request side
                    len = $urandom_range(150, 300);
                    repeat (len) begin
                        @(posedge i_clk);
                        res_ch.ready <= 1'b0;
                    end
                end
            endcase
            seg++;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result('{tx_valid:      res_ch.tx_valid,
                              tx_frame:      res_ch.tx_frame,
                              notify_valid:  res_ch.notify_valid,
                              notify_status: res_ch.notify_status,
                              notify_word:   res_ch.notify_word});
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[spi_frame_check_with_retry] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int sent;
        t_item req;
        sb           = new();
        burst_left   = 1;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_DUMMY_COMMAND;
        i_cfg_data   = '0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_SEND;
        in_ch.default_word = '0;
        in_ch.field_mask   = '0;
        in_ch.field_data   = '0;
        in_ch.reply_word   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings (dummy 0, budget 3, no retries loaded)
        offer(reply_item(16'h0000));                 // zero before dummy: fetch
        offer(reply_item(16'h0000));                 // zero after dummy, no retries
        offer(filler_item(KIND_RELOAD));
        offer(send_item(16'hFFFF, 16'h0000, 16'h0000));
        offer(send_item(16'h0000, 16'hFFFF, 16'hFFFF));
        offer(send_item(16'h0000, 16'h0000, 16'h0000));
        offer(send_item(16'hA5A5, 16'h0F0F, 16'h5A5A));
        offer(reply_item(16'h8000));                 // wrong nibble before dummy
        offer(reply_item(16'h0123));                 // dummy nibble match: fetch
        offer(reply_item(16'h0000));                 // resend, one retry used
        offer(reply_item(16'h0000));                 // fetch again
        offer(reply_item({sb.stored_cmd[15:12], 12'hFFF}));  // echo ok
        offer(reply_item({~sb.stored_cmd[15:12], 12'h001})); // wrong echo
        offer(reply_item(16'hFFFF));
        offer(reply_item(16'h0000));                 // resend
        offer(reply_item(16'h0000));                 // fetch
        offer(reply_item(16'h0000));                 // last retry
        offer(reply_item(16'h0000));                 // fetch
        offer(reply_item(16'h0000));                 // budget spent: failure
        req = filler_item(2'd3);
        req.default_word = 16'hFFFF;
        req.field_mask   = 16'hFFFF;
        req.field_data   = 16'hFFFF;
        req.reply_word   = 16'hFFFF;
        offer(req);                                  // unused kind
        offer(filler_item(KIND_RELOAD));
        offer(send_item(16'hFFFF, 16'hFFFF, 16'h0000));
        settle();

        // Random phases over a spread of register settings
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_DUMMY_COMMAND, 16'hFFFF);
                    write_reg(REG_RETRY_BUDGET, 16'h0000);
                end
                1: begin
                    write_reg(REG_DUMMY_COMMAND, 16'h0000);
                    write_reg(REG_RETRY_BUDGET, 16'h00FF);
                end
                2: begin
                    write_reg(REG_DUMMY_COMMAND, 16'($urandom));
                    write_reg(REG_RETRY_BUDGET, 16'd3);
                end
                3: begin
                    write_reg(REG_DUMMY_COMMAND, 16'($urandom));
                    write_reg(REG_RETRY_BUDGET, 16'($urandom_range(1, 4)));
                end
                default: begin
                    write_reg(REG_DUMMY_COMMAND, 16'($urandom));
                    write_reg(REG_RETRY_BUDGET, 16'($urandom_range(0, 255)));
                end
            endcase
            i_cfg_we <= 1'b0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                req = random_item();
                offer(req);
                if (req.kind != 2'd3) sent++;
            end
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
        if (sb.mismatches == 0) begin
            $display("[spi_frame_check_with_retry] OK");
        end else begin
            $display("[spi_frame_check_with_retry] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sfc_pkg.sv
design/sfc_in_if.sv
design/sfc_out_if.sv
design/sfc_cfg_regs.sv
design/sfc_engine.sv
design/spi_frame_check_with_retry.sv
design/sfc_check.sv
tb/tb_top.sv
